// ===== rtl/skvt_pkg.sv =====
// shared types, constants and command/status structs for the sorted key/data table
// no dependencies; used by every module of the block but skvt_ram
package skvt_pkg;

  // table size and derived widths
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 64;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_SEARCH = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // operations on the found-data register
  localparam logic [1:0] FND_HOLD = 2'd0;
  localparam logic [1:0] FND_ZERO = 2'd1;
  localparam logic [1:0] FND_ONES = 2'd2;
  localparam logic [1:0] FND_CAP  = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] req_key;
    logic signed [31:0] req_data;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_data;
    logic [4:0]         entry_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic       load_req;
    logic       idx_clr;
    logic       idx_to_cnt;
    logic       idx_inc;
    logic       idx_dec;
    logic       rd_en;
    logic       rd_prev;
    logic       wr_en;
    logic       wr_new;
    logic       wr_prev;
    logic       cnt_inc;
    logic       cnt_dec;
    logic [1:0] found_op;
    logic       res_load;
    logic [1:0] res_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       idx_zero;
    logic       idx_at_cnt;
    logic       full;
    logic       key_lt;
    logic       key_eq;
  } dp_sts_t;

endpackage

// ===== rtl/skvt_ram.sv =====
// generic single write, single read memory with registered read data
// no dependencies
module skvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                wdata,
  input  logic                            re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/skvt_datapath.sv =====
// datapath: request register, entry pointer, count, entry memory and result register
// depends on skvt_pkg and skvt_ram
module skvt_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  skvt_pkg::req_t    in_item,
  input  skvt_pkg::dp_cmd_t cmd,
  output skvt_pkg::dp_sts_t sts,
  output skvt_pkg::rsp_t    out_item
);
  import skvt_pkg::*;

  localparam int CNT_X = (CNT_W > 5) ? CNT_W : 5;

  req_t               req_r;
  logic [CNT_W-1:0]   idx_r;
  logic [CNT_W-1:0]   idx_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [CNT_W-1:0]   idx_m1;
  logic signed [31:0] found_r;
  rsp_t               out_r;
  logic [CNT_X-1:0]   cnt_ext;

  logic [ADDR_W-1:0]  rd_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  logic signed [31:0] rd_key;

  assign idx_m1 = idx_r - CNT_W'(1);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_item;
    end
  end

  // entry pointer
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_to_cnt) begin
      idx_nxt = cnt_r;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CNT_W'(1);
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_m1;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  // entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // entry memory, key in the upper half
  assign rd_addr = cmd.rd_prev ? idx_m1[ADDR_W-1:0] : idx_r[ADDR_W-1:0];
  assign wr_addr = cmd.wr_prev ? idx_m1[ADDR_W-1:0] : idx_r[ADDR_W-1:0];
  assign wr_data = cmd.wr_new ? {req_r.req_key, req_r.req_data} : rd_data;

  skvt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign rd_key = rd_data[ENTRY_W-1:32];

  // found data register
  always_ff @(posedge clk) begin
    case (cmd.found_op)
      FND_HOLD: found_r <= found_r;
      FND_ZERO: found_r <= '0;
      FND_ONES: found_r <= '1;
      FND_CAP:  found_r <= rd_data[31:0];
      default:  found_r <= found_r;
    endcase
  end

  // result register
  assign cnt_ext = CNT_X'(cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r.status      <= cmd.res_status;
      out_r.found_data  <= found_r;
      out_r.entry_count <= cnt_ext[4:0];
    end
  end

  assign out_item = out_r;

  // status back to the controller
  assign sts.req_type   = req_r.req_type;
  assign sts.idx_zero   = (idx_r == '0);
  assign sts.idx_at_cnt = (idx_r == cnt_r);
  assign sts.full       = (cnt_r == CNT_W'(CAPACITY));
  assign sts.key_lt     = (rd_key < req_r.req_key);
  assign sts.key_eq     = (rd_key == req_r.req_key);

endmodule

// ===== rtl/skvt_ctrl.sv =====
// controller: sequences the scan and shift over the entry memory, owns the handshakes
// depends on skvt_pkg
module skvt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  skvt_pkg::dp_sts_t sts,
  output skvt_pkg::dp_cmd_t cmd
);
  import skvt_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_INS_CHK  = 4'd2;
  localparam logic [3:0] S_INS_EV   = 4'd3;
  localparam logic [3:0] S_SCAN_CHK = 4'd4;
  localparam logic [3:0] S_SCAN_EV  = 4'd5;
  localparam logic [3:0] S_SHF_CHK  = 4'd6;
  localparam logic [3:0] S_SHF_EV   = 4'd7;
  localparam logic [3:0] S_FIN      = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic [1:0] status_r;
  logic [1:0] status_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       is_search;

  assign is_search = (sts.req_type == REQ_SEARCH);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.found_op   = FND_HOLD;
    cmd.res_status = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_START;
        end
      end
      S_START: begin
        cmd.found_op = FND_ZERO;
        status_nxt   = ST_OK;
        case (sts.req_type)
          REQ_INSERT: begin
            if (sts.full) begin
              status_nxt = ST_FULL;
              state_nxt  = S_FIN;
            end else begin
              cmd.idx_to_cnt = 1'b1;
              state_nxt      = S_INS_CHK;
            end
          end
          REQ_DELETE, REQ_SEARCH: begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_SCAN_CHK;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      // insert walks down from the top, moving up every entry not below the key
      S_INS_CHK: begin
        if (sts.idx_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_prev = 1'b1;
          state_nxt   = S_INS_EV;
        end
      end
      S_INS_EV: begin
        cmd.wr_en = 1'b1;
        if (!sts.key_lt) begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_INS_CHK;
        end else begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      // search and delete walk up to the first entry not below the key
      S_SCAN_CHK: begin
        if (sts.idx_at_cnt) begin
          status_nxt = ST_NOT_FOUND;
          if (is_search) begin
            cmd.found_op = FND_ONES;
          end
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (sts.key_lt) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_CHK;
        end else if (sts.key_eq) begin
          if (is_search) begin
            cmd.found_op = FND_CAP;
            state_nxt    = S_FIN;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_SHF_CHK;
          end
        end else begin
          status_nxt = ST_NOT_FOUND;
          if (is_search) begin
            cmd.found_op = FND_ONES;
          end
          state_nxt = S_FIN;
        end
      end
      // delete closes the gap, moving each later entry down by one
      S_SHF_CHK: begin
        if (sts.idx_at_cnt) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SHF_EV;
        end
      end
      S_SHF_EV: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_prev = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_SHF_CHK;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/sorted_key_value_table.sv =====
// Sorted key/data table, up to CAPACITY signed 32-bit key and data pairs kept in
// ascending key order in one entry memory. Each item is an insert, a delete or a
// search (any other request code changes nothing) and yields one result. The
// controller takes no new item until it is through with the last one. An insert
// moves every entry at or above its key up by one. A search walks to the first
// entry not below the key. A delete walks there and then moves each later entry
// down. The longest item is a delete, or a search past the last key, on a full
// table. Each entry visited costs one read of the single-port-pair memory, and a
// write as well when the entry moves. A finished result sits in the output
// register and the next item is taken while it waits. A result still waiting
// there holds back the result after it.
// depends on skvt_pkg, skvt_ctrl, skvt_datapath
module sorted_key_value_table (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  skvt_pkg::req_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output skvt_pkg::rsp_t out_item
);
  import skvt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  skvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and compare
  skvt_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cmd     (cmd),
    .sts     (sts),
    .out_item(out_item)
  );

`ifndef SYNTHESIS
  // one item at a time: no new item right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item taken while another is in progress");

  // never grow a full table
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !sts.full)
    else $error("insert into a full table");

  // a refused insert is reported only when the table is full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_load && cmd.res_status == ST_FULL) |-> sts.full)
    else $error("full status with room left");

  // memory read and write never issued together
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_en && cmd.wr_en))
    else $error("read and write in the same cycle");
`endif

endmodule

// ===== tb/sorted_key_value_table_checker.sv =====
// result checker for the sorted key/data table: watches both channels, keeps its
// own copy of the table, predicts each result and compares it field by field
// depends on skvt_pkg
`timescale 1ns / 100ps

module sorted_key_value_table_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  skvt_pkg::req_t in_item,
  input  logic           out_valid,
  input  logic           out_ready,
  input  skvt_pkg::rsp_t out_item,
  output int             fail_count,
  output int             outstanding
);
  import skvt_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // shadow copy of the table, packed at the low positions in key order
  logic signed [31:0] key_mem [CAPACITY];
  logic signed [31:0] dat_mem [CAPACITY];
  int                 held;

  rsp_t due_replies [$];
  int   errors = 0;

  // first position whose key is not below k, or held when there is none
  function automatic int first_not_below(input logic signed [31:0] k);
    int p;
    p = 0;
    while (p < held && key_mem[p] < k) p++;
    return p;
  endfunction

  // apply one request to the shadow table and return the reply it should give
  function automatic rsp_t table_update(input req_t r);
    rsp_t o;
    int   pos;
    int   i;
    o.status     = ST_OK;
    o.found_data = '0;
    case (r.req_type)
      REQ_INSERT: begin
        if (held >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          // new pair goes ahead of any equal keys
          pos = first_not_below(r.req_key);
          for (i = held; i > pos; i--) begin
            key_mem[i] = key_mem[i-1];
            dat_mem[i] = dat_mem[i-1];
          end
          key_mem[pos] = r.req_key;
          dat_mem[pos] = r.req_data;
          held++;
        end
      end
      REQ_DELETE: begin
        pos = first_not_below(r.req_key);
        if (pos < held && key_mem[pos] == r.req_key) begin
          for (i = pos; i + 1 < held; i++) begin
            key_mem[i] = key_mem[i+1];
            dat_mem[i] = dat_mem[i+1];
          end
          held--;
        end else begin
          o.status = ST_NOT_FOUND;
        end
      end
      REQ_SEARCH: begin
        pos = first_not_below(r.req_key);
        if (pos < held && key_mem[pos] == r.req_key) begin
          o.found_data = dat_mem[pos];
        end else begin
          o.status     = ST_NOT_FOUND;
          o.found_data = '1;
        end
      end
      default: begin
        // unused request code leaves the table alone
      end
    endcase
    o.entry_count = 5'(held);
    return o;
  endfunction

  // sample both handshakes at each edge
  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst_n) begin
      held = 0;
      due_replies.delete();
    end else begin
      if (in_valid && in_ready) due_replies.push_back(table_update(in_item));
      if (out_valid && out_ready) begin
        if (due_replies.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("unexpected item: status %0d data %0d count %0d",
                     out_item.status, out_item.found_data, out_item.entry_count);
        end else begin
          want = due_replies.pop_front();
          if (out_item !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("mismatch: status %0d/%0d data %0d/%0d count %0d/%0d (exp/got)",
                       want.status, out_item.status, want.found_data,
                       out_item.found_data, want.entry_count, out_item.entry_count);
          end
        end
      end
    end
    fail_count  <= errors;
    outstanding <= due_replies.size();
  end

endmodule

// ===== tb/sorted_key_value_table_test.sv =====
// top of the sorted key/data table testbench: clock, reset, request stimulus,
// result back-pressure and the verdict
// depends on skvt_pkg, sorted_key_value_table, sorted_key_value_table_checker
`timescale 1ns / 100ps

module sorted_key_value_table_test;
  import skvt_pkg::*;

  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam int          PHASE_ITEMS = 500;
  localparam int          HOLD_CYCLES = 300;
  localparam logic [31:0] KEY_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] KEY_MIN     = 32'h8000_0000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  req_t in_item   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_item;

  int   fail_count;
  int   outstanding;
  int   stall_pct   = 0;
  int   idle_pct    = 0;
  logic hold_off    = 1'b0;
  logic pressure_go = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_key_value_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  sorted_key_value_table_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin : receiver_hold
    do @(posedge clk); while (!pressure_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // offer one item after a random gap and wait for it to be taken
  task automatic send_item(input logic [1:0] t, input logic [31:0] k, input logic [31:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_item.req_type <= t;
    in_item.req_key  <= k;
    in_item.req_data <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly a small pool of keys so that hits and duplicates are common
  function automatic logic [31:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 75) return 32'(int'($urandom_range(15)) - 8);
    if (roll < 90) return $urandom;
    case ($urandom_range(3))
      0:       return KEY_MAX;
      1:       return KEY_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(9))
      0:       return KEY_MAX;
      1:       return KEY_MIN;
      default: return $urandom;
    endcase
  endfunction

  // request code, insert-heavy and delete-heavy windows in turn
  function automatic logic [1:0] pick_type(input int n);
    int unsigned roll;
    int          ins_pct;
    roll    = $urandom_range(99);
    ins_pct = ((n / 64) % 2 == 0) ? 65 : 30;
    if (roll < 3) return REQ_UNUSED;
    if (roll < 3 + ins_pct) return REQ_INSERT;
    return $urandom_range(1) ? REQ_DELETE : REQ_SEARCH;
  endfunction

  initial begin : stimulus
    int idle_tab [4];
    int stall_tab [4];
    idle_tab  = '{0, 71, 0, 26};
    stall_tab = '{0, 0, 71, 26};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, unused code, extremes, equal keys
    send_item(REQ_SEARCH, 32'd5, '0);
    send_item(REQ_DELETE, 32'd5, '0);
    send_item(REQ_UNUSED, '1, '1);
    send_item(REQ_INSERT, KEY_MAX, KEY_MIN);
    send_item(REQ_INSERT, KEY_MIN, KEY_MAX);
    send_item(REQ_INSERT, '0, '1);
    send_item(REQ_INSERT, '0, 32'd5);
    send_item(REQ_SEARCH, '0, '1);
    send_item(REQ_DELETE, '0, '0);
    send_item(REQ_SEARCH, '0, '0);
    send_item(REQ_SEARCH, KEY_MAX, '0);
    send_item(REQ_SEARCH, KEY_MIN, '0);
    // fill to capacity, then a refused insert and a delete of a missing key
    repeat (CAPACITY - 3) send_item(REQ_INSERT, $urandom, $urandom);
    send_item(REQ_INSERT, 32'd7, 32'd7);
    send_item(REQ_DELETE, 32'd12345, '0);

    // random requests across the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct <= stall_tab[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 0 && n == 200) pressure_go <= 1'b1;
        send_item(pick_type(n), pick_key(), pick_data());
      end
    end
    in_valid <= 1'b0;

    // drain: let the checker see the last accept, then wait for every reply
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (48) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
